// ===== hw/rtl/sliding_polynomial_fit_filter_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sliding polynomial fit filter
// Clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SLIDING_POLYNOMIAL_FIT_FILTER_ASSERT_SVH
`define SLIDING_POLYNOMIAL_FIT_FILTER_ASSERT_SVH

// same-cycle implication
`define SPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/spf_pkg.sv =====
// ---------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the sliding polynomial fit filter.
// ---------------------------------------------------------------------------
package spf_pkg;

  localparam int unsigned TermBits = 56;
  localparam int unsigned NumTerms = 4;

  typedef struct packed {
    logic       push;
    logic       shift;
    logic       mul;
    logic       acc;
    logic [1:0] tsel;
  } ctl_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_MUL   = 5'b00100,
    S_ACC   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

endpackage

// ===== hw/rtl/sliding_polynomial_fit_filter.sv =====
// ---------------------------------------------------------------------------
// sliding_polynomial_fit_filter
// Least-squares polynomial fit over a sliding sample window, built as a
// chain of tap cells.
// ---------------------------------------------------------------------------
// A load transfer (tuser 0) writes one weight. A sample transfer (tuser 1)
// runs a full pass before its result is offered, len being the effective
// window length: the operand chain first slides the window of len samples
// down to tap 0 one tap per cycle, every cell then forms its four
// products, and the partial sums ripple through all WINDOW_MAX cells.
// Reset clears samples and weights at once.
// ---------------------------------------------------------------------------
module sliding_polynomial_fit_filter #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned WEIGHT_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [6:0]   cfg_data_i,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [1:0] table_select, [7:2] tap_index, [39:8] weight_value, [55:40] sample
  input  logic [55:0]  s_tdata,
  // [0] op
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [55:0] cubic_term, [111:56] quadratic_term, [167:112] linear_term,
  // [223:168] constant_term
  output logic [223:0] m_tdata,
  // [0] window_full
  output logic         m_tuser
);

  localparam int unsigned TB    = spf_pkg::TermBits;
  localparam int unsigned NT    = spf_pkg::NumTerms;
  localparam int unsigned LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CW    = $clog2(WINDOW_MAX);

  localparam logic CFG_FIT_ORDER = 1'b0;
  localparam logic CFG_WIN_LEN   = 1'b1;
  localparam logic OP_LOAD       = 1'b0;
  localparam logic OP_PUSH       = 1'b1;

  logic [1:0]          fit_order_q;
  logic [6:0]          win_len_q;
  spf_pkg::state_e     state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [LEN_W-1:0]    fill_q, fill_d;
  logic                full_q, full_d;
  logic                m_valid_q, m_valid_d;
  logic [NT*TB-1:0]    out_q;
  logic                out_full_q;

  logic [LEN_W-1:0]    eff_len;
  logic [LEN_W-1:0]    base_full;
  logic [CW-1:0]       base;
  logic                accept;
  logic                push;
  logic                load;
  spf_pkg::ctl_t       ctl;

  logic [1:0]                     tsel;
  logic [5:0]                     tap;
  logic signed [WEIGHT_BITS-1:0]  new_weight;
  logic [SAMPLE_BITS+15:0]        smp_ext;
  logic signed [SAMPLE_BITS-1:0]  new_sample;

  logic signed [WINDOW_MAX-1:0][SAMPLE_BITS-1:0] smp;
  logic signed [WINDOW_MAX-1:0][SAMPLE_BITS-1:0] opr;
  logic [WINDOW_MAX-1:0][NT-1:0][TB-1:0]         acc;

  assign tsel       = s_tdata[1:0];
  assign tap        = s_tdata[7:2];
  assign new_weight = s_tdata[8 +: WEIGHT_BITS];
  assign smp_ext    = {SAMPLE_BITS'(0), s_tdata[55:40]};
  assign new_sample = smp_ext[SAMPLE_BITS-1:0];

  assign s_tready = (state_q == spf_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (s_tuser == OP_PUSH);
  assign load     = accept && (s_tuser == OP_LOAD);

  always_comb begin
    if (win_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(win_len_q) > int'(WINDOW_MAX)) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = LEN_W'(win_len_q);
    end
  end

  assign base_full = LEN_W'(WINDOW_MAX) - eff_len;
  assign base      = base_full[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_order_q <= '0;
      win_len_q   <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIT_ORDER: fit_order_q <= cfg_data_i[1:0];
        CFG_WIN_LEN:   win_len_q   <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    fill_d    = fill_q;
    full_d    = full_q;
    m_valid_d = m_valid_q;
    ctl       = '0;
    ctl.tsel  = tsel;
    if (m_valid_q && m_tready) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      spf_pkg::S_IDLE: begin
        if (push) begin
          ctl.push = 1'b1;
          if (fill_q != LEN_W'(WINDOW_MAX)) begin
            fill_d = fill_q + LEN_W'(1);
          end
          full_d  = (fill_d >= eff_len);
          cnt_d   = base;
          state_d = (base != '0) ? spf_pkg::S_SHIFT : spf_pkg::S_MUL;
        end
      end
      spf_pkg::S_SHIFT: begin
        ctl.shift = 1'b1;
        cnt_d     = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = spf_pkg::S_MUL;
        end
      end
      spf_pkg::S_MUL: begin
        ctl.mul = 1'b1;
        cnt_d   = CW'(WINDOW_MAX - 1);
        state_d = spf_pkg::S_ACC;
      end
      spf_pkg::S_ACC: begin
        ctl.acc = 1'b1;
        cnt_d   = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = spf_pkg::S_DONE;
        end
      end
      spf_pkg::S_DONE: begin
        if (!m_valid_q || m_tready) begin
          m_valid_d = 1'b1;
          state_d   = spf_pkg::S_IDLE;
        end
      end
      default: state_d = spf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spf_pkg::S_IDLE;
      cnt_q     <= '0;
      fill_q    <= '0;
      full_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      fill_q    <= fill_d;
      full_q    <= full_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == spf_pkg::S_DONE && (!m_valid_q || m_tready)) begin
      for (int t = 0; t < NT; t++) begin
        out_q[t*TB +: TB] <= (int'(fit_order_q) >= 3 - t) ? acc[WINDOW_MAX-1][t] : '0;
      end
      out_full_q <= full_q;
    end
  end

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] smp_next;
    logic signed [SAMPLE_BITS-1:0] op_next;
    logic [NT-1:0][TB-1:0]         acc_in;
    logic                          hit;

    if (j == WINDOW_MAX - 1) begin : g_top
      assign smp_next = new_sample;
      assign op_next  = '0;
    end else begin : g_mid
      assign smp_next = smp[j+1];
      assign op_next  = opr[j+1];
    end
    if (j == 0) begin : g_first
      assign acc_in = '0;
    end else begin : g_rest
      assign acc_in = acc[j-1];
    end
    assign hit = load && (int'(tap) == j);

    spf_cell #(
      .SampleBits(SAMPLE_BITS),
      .WeightBits(WEIGHT_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .load_i     (hit),
      .weight_i   (new_weight),
      .smp_next_i (smp_next),
      .op_next_i  (op_next),
      .acc_i      (acc_in),
      .smp_o      (smp[j]),
      .op_o       (opr[j]),
      .acc_o      (acc[j])
    );
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = out_q;
  assign m_tuser  = out_full_q;

`include "sliding_polynomial_fit_filter_assert.svh"

  `SPF_ASSERT_IMP(a_valid_from_done, $rose(m_tvalid), $past(state_q == spf_pkg::S_DONE), "result without finished pass")
  `SPF_ASSERT_NXT(a_push_starts, push, (state_q == spf_pkg::S_SHIFT) || (state_q == spf_pkg::S_MUL), "push did not start pass")
  `SPF_ASSERT_NXT(a_acc_ends, (state_q == spf_pkg::S_ACC) && (cnt_q == '0), state_q == spf_pkg::S_DONE, "sum ripple overran")

endmodule

// ===== hw/rtl/spf_cell.sv =====
// ---------------------------------------------------------------------------
// spf_cell
// One window tap: sample, aligned operand, four weights, products and
// partial sums passed on to the next tap.
// ---------------------------------------------------------------------------
module spf_cell #(
  parameter int unsigned SampleBits = 16,
  parameter int unsigned WeightBits = 32
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  spf_pkg::ctl_t                                         ctl_i,
  input  logic                                                  load_i,
  input  logic signed [WeightBits-1:0]                          weight_i,
  input  logic signed [SampleBits-1:0]                          smp_next_i,
  input  logic signed [SampleBits-1:0]                          op_next_i,
  input  logic [spf_pkg::NumTerms-1:0][spf_pkg::TermBits-1:0]   acc_i,
  output logic signed [SampleBits-1:0]                          smp_o,
  output logic signed [SampleBits-1:0]                          op_o,
  output logic [spf_pkg::NumTerms-1:0][spf_pkg::TermBits-1:0]   acc_o
);

  logic signed [SampleBits-1:0]                         sample_q;
  logic signed [SampleBits-1:0]                         oper_q;
  logic signed [spf_pkg::NumTerms-1:0][WeightBits-1:0]  weight_q;
  logic [spf_pkg::NumTerms-1:0][spf_pkg::TermBits-1:0]  prod_q;
  logic [spf_pkg::NumTerms-1:0][spf_pkg::TermBits-1:0]  acc_q;
  logic signed [SampleBits+WeightBits-1:0]              mul_full [spf_pkg::NumTerms];

  for (genvar g = 0; g < spf_pkg::NumTerms; g++) begin : g_mul
    assign mul_full[g] = oper_q * $signed(weight_q[g]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      weight_q <= '0;
    end else begin
      if (ctl_i.push) begin
        sample_q <= smp_next_i;
      end
      if (load_i) begin
        weight_q[ctl_i.tsel] <= weight_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      oper_q <= smp_next_i;
    end else if (ctl_i.shift) begin
      oper_q <= op_next_i;
    end
    for (int t = 0; t < spf_pkg::NumTerms; t++) begin
      if (ctl_i.mul) begin
        prod_q[t] <= spf_pkg::TermBits'(mul_full[t]);
        acc_q[t]  <= '0;
      end else if (ctl_i.acc) begin
        acc_q[t]  <= acc_i[t] + prod_q[t];
      end
    end
  end

  assign smp_o = sample_q;
  assign op_o  = oper_q;
  assign acc_o = acc_q;

endmodule
